[design/imu_sfp_pkg.sv]
// imu_sfp_pkg: constants shared by the serial imu frame parser
// header and type codes, seen-mask bits, event codes, default frame length
// no dependencies
`default_nettype none

package imu_sfp_pkg;

	localparam int FRAME_BYTES_DEF = 11;
	localparam int POS_W           = 4;

	localparam logic [7:0] HEADER_BYTE = 8'h55;
	localparam logic [7:0] TYPE_ACCEL  = 8'h51;
	localparam logic [7:0] TYPE_GYRO   = 8'h52;
	localparam logic [7:0] TYPE_ANGLE  = 8'h53;

	localparam logic [2:0] SEEN_ACCEL = 3'h1;
	localparam logic [2:0] SEEN_GYRO  = 3'h2;
	localparam logic [2:0] SEEN_ANGLE = 3'h4;
	localparam logic [2:0] SEEN_ALL   = 3'h7;

	localparam logic [2:0] EV_FORMAT_ERR = 3'd0;
	localparam logic [2:0] EV_CHECK_ERR  = 3'd1;
	localparam logic [2:0] EV_ACCEL      = 3'd2;
	localparam logic [2:0] EV_GYRO       = 3'd3;
	localparam logic [2:0] EV_ANGLE      = 3'd4;

endpackage

`default_nettype wire

[design/imu_serial_frame_parser.sv]
// imu_serial_frame_parser: byte-wise parser for 11..16 byte serial imu frames
// output: each result is registered in the output register when the byte that causes it is taken
// throughput: one byte per cycle; input stalls only while a result waits and out_ready is low
// checksum is kept as a running sum, so the last byte needs one 8-bit compare
// reset: arst_n clears position, seen mask, error/complete totals and output valid
// depends on imu_sfp_pkg
`default_nettype none

module imu_serial_frame_parser #(
	parameter int FRAME_BYTES = imu_sfp_pkg::FRAME_BYTES_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [7:0]         rx_byte,
	input  wire logic [31:0]        time_ms,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [2:0]              event_res,
	output logic signed [15:0]      axis_x,
	output logic signed [15:0]      axis_y,
	output logic signed [15:0]      axis_z,
	output logic signed [15:0]      temp_raw,
	output logic                    sample_complete,
	output logic [31:0]             stamp_ms,
	output logic [31:0]             format_errors,
	output logic [31:0]             checksum_errors,
	output logic [31:0]             complete_count
);
	import imu_sfp_pkg::*;

	localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
	localparam logic [POS_W-1:0] POS_HUNT = '0;
	localparam logic [POS_W-1:0] POS_TYPE = POS_W'(1);

	// state
	logic [POS_W-1:0] pos_q;
	logic [7:0]       sum_q;
	logic [2:0]       seen_q;
	logic [31:0]      fmt_tot_q;
	logic [31:0]      cks_tot_q;
	logic [31:0]      cmp_tot_q;
	logic [7:0]       frame_q [1:9];

	// output register
	logic               out_valid_q;
	logic [2:0]         ev_q;
	logic signed [15:0] ax_q, ay_q, az_q, temp_q;
	logic               cmpl_q;
	logic [31:0]        stamp_q, fmt_out_q, cks_out_q, cmp_out_q;

	// next-state and result logic
	logic               accept;
	logic               fire;
	logic               store_en;
	logic [POS_W-1:0]   pos_d;
	logic [7:0]         sum_d;
	logic [2:0]         seen_d;
	logic [31:0]        fmt_tot_d, cks_tot_d, cmp_tot_d;
	logic [2:0]         ev_d;
	logic signed [15:0] ax_d, ay_d, az_d, temp_d;
	logic               cmpl_d;
	logic [31:0]        stamp_d;
	logic [2:0]         seen_or;

	assign in_ready = !out_valid_q || out_ready;
	assign accept   = in_valid && in_ready;

	always_comb begin
		fire      = 1'b0;
		store_en  = 1'b0;
		pos_d     = pos_q;
		sum_d     = sum_q;
		seen_d    = seen_q;
		fmt_tot_d = fmt_tot_q;
		cks_tot_d = cks_tot_q;
		cmp_tot_d = cmp_tot_q;
		ev_d      = EV_FORMAT_ERR;
		ax_d      = '0;
		ay_d      = '0;
		az_d      = '0;
		temp_d    = '0;
		cmpl_d    = 1'b0;
		stamp_d   = '0;
		seen_or   = seen_q;
		priority if (pos_q == POS_HUNT) begin
			if (rx_byte == HEADER_BYTE) begin
				pos_d = POS_TYPE;
				sum_d = rx_byte;
			end
		end else if (pos_q == POS_TYPE && (rx_byte < TYPE_ACCEL || rx_byte > TYPE_ANGLE)) begin
			fire      = 1'b1;
			ev_d      = EV_FORMAT_ERR;
			fmt_tot_d = fmt_tot_q + 32'd1;
			// a second header resyncs at the type position
			if (rx_byte == HEADER_BYTE) begin
				pos_d = POS_TYPE;
				sum_d = rx_byte;
			end else begin
				pos_d = POS_HUNT;
			end
		end else if (pos_q != LAST_POS) begin
			store_en = 1'b1;
			sum_d    = sum_q + rx_byte;
			pos_d    = pos_q + POS_W'(1);
		end else begin
			pos_d = POS_HUNT;
			fire  = 1'b1;
			if (sum_q != rx_byte) begin
				ev_d      = EV_CHECK_ERR;
				cks_tot_d = cks_tot_q + 32'd1;
			end else begin
				ax_d = {frame_q[3], frame_q[2]};
				ay_d = {frame_q[5], frame_q[4]};
				az_d = {frame_q[7], frame_q[6]};
				priority if (frame_q[1] == TYPE_ACCEL) begin
					ev_d    = EV_ACCEL;
					temp_d  = {frame_q[9], frame_q[8]};
					seen_or = seen_q | SEEN_ACCEL;
				end else if (frame_q[1] == TYPE_GYRO) begin
					ev_d    = EV_GYRO;
					seen_or = seen_q | SEEN_GYRO;
				end else begin
					ev_d    = EV_ANGLE;
					seen_or = seen_q | SEEN_ANGLE;
				end
				if (seen_or == SEEN_ALL) begin
					seen_d    = '0;
					cmp_tot_d = cmp_tot_q + 32'd1;
					cmpl_d    = 1'b1;
					stamp_d   = time_ms;
				end else begin
					seen_d = seen_or;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= POS_HUNT;
			sum_q     <= '0;
			seen_q    <= '0;
			fmt_tot_q <= '0;
			cks_tot_q <= '0;
			cmp_tot_q <= '0;
		end else if (accept) begin
			pos_q     <= pos_d;
			sum_q     <= sum_d;
			seen_q    <= seen_d;
			fmt_tot_q <= fmt_tot_d;
			cks_tot_q <= cks_tot_d;
			cmp_tot_q <= cmp_tot_d;
		end
	end

	// frame bytes 1..9: type code and the four 16-bit words
	always_ff @(posedge clk) begin
		for (int i = 1; i <= 9; i++) begin
			if (accept && store_en && pos_q == POS_W'(i)) begin
				frame_q[i] <= rx_byte;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && fire) begin
			ev_q      <= ev_d;
			ax_q      <= ax_d;
			ay_q      <= ay_d;
			az_q      <= az_d;
			temp_q    <= temp_d;
			cmpl_q    <= cmpl_d;
			stamp_q   <= stamp_d;
			fmt_out_q <= fmt_tot_d;
			cks_out_q <= cks_tot_d;
			cmp_out_q <= cmp_tot_d;
		end
	end

	assign out_valid       = out_valid_q;
	assign event_res       = ev_q;
	assign axis_x          = ax_q;
	assign axis_y          = ay_q;
	assign axis_z          = az_q;
	assign temp_raw        = temp_q;
	assign sample_complete = cmpl_q;
	assign stamp_ms        = stamp_q;
	assign format_errors   = fmt_out_q;
	assign checksum_errors = cks_out_q;
	assign complete_count  = cmp_out_q;

endmodule

`default_nettype wire

[verif/testbench.sv]
// testbench: self-checking bench for imu_serial_frame_parser
// drives serial byte streams with random gaps and output stalls, predicts each result
// depends on imu_sfp_pkg and the parser rtl
`default_nettype none

module testbench;
	import imu_sfp_pkg::*;

	localparam int FRAME_LEN   = FRAME_BYTES_DEF;
	localparam int ITEM_TARGET = 1650;
	localparam int CALM_FROM   = 800;
	localparam int CALM_TO     = 1500;

	typedef struct packed {
		logic [2:0]  ev;
		logic [15:0] x, y, z, temp;
		logic        done;
		logic [31:0] stamp, n_fmt, n_sum, n_cpl;
	} imu_result_t;

	typedef struct {
		logic [7:0]  b;
		logic [31:0] t;
		bit          hold;
	} rx_item_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  rx_byte = 8'h00;
	logic [31:0] time_ms = 32'h0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  event_res;
	logic signed [15:0] axis_x, axis_y, axis_z, temp_raw;
	logic        sample_complete;
	logic [31:0] stamp_ms, format_errors, checksum_errors, complete_count;

	imu_serial_frame_parser dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_ready        (in_ready),
		.rx_byte         (rx_byte),
		.time_ms         (time_ms),
		.out_valid       (out_valid),
		.out_ready       (out_ready),
		.event_res       (event_res),
		.axis_x          (axis_x),
		.axis_y          (axis_y),
		.axis_z          (axis_z),
		.temp_raw        (temp_raw),
		.sample_complete (sample_complete),
		.stamp_ms        (stamp_ms),
		.format_errors   (format_errors),
		.checksum_errors (checksum_errors),
		.complete_count  (complete_count)
	);

	always #1 clk = ~clk;

	rx_item_t    byte_queue[$];
	imu_result_t expected_results[$];
	logic        awaiting_results = 1'b0;
	int          n_items = 0;
	int          n_errors = 0;
	int          cyc = 0;
	wire         calm = cyc >= CALM_FROM && cyc < CALM_TO;

	// parser shadow state
	logic [3:0]  frame_pos = 4'd0;
	logic [7:0]  frame_buf [0:15];
	logic [2:0]  seen_mask = 3'd0;
	logic [31:0] n_format = 32'd0;
	logic [31:0] n_checksum = 32'd0;
	logic [31:0] n_complete = 32'd0;

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		n_errors++;
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
			input logic [31:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	// advance the shadow parser by one byte, queue the result it causes
	task automatic track_byte(input logic [7:0] b, input logic [31:0] now);
		imu_result_t r;
		logic [7:0]  sum;
		bit          emit;
		r = '0;
		emit = 1'b0;
		if (frame_pos == 4'd0) begin
			if (b == HEADER_BYTE) begin
				frame_buf[0] = b;
				frame_pos = 4'd1;
			end
		end else if (frame_pos == 4'd1 && (b < TYPE_ACCEL || b > TYPE_ANGLE)) begin
			n_format++;
			emit = 1'b1;
			r.ev = EV_FORMAT_ERR;
			// a header in the type slot restarts the frame
			if (b == HEADER_BYTE) begin
				frame_buf[0] = b;
				frame_pos = 4'd1;
			end else begin
				frame_pos = 4'd0;
			end
		end else if (frame_pos < FRAME_LEN - 1) begin
			frame_buf[frame_pos] = b;
			frame_pos = frame_pos + 4'd1;
		end else begin
			frame_pos = 4'd0;
			emit = 1'b1;
			sum = 8'h00;
			for (int i = 0; i < FRAME_LEN - 1; i++)
				sum = sum + frame_buf[i];
			if (sum != b) begin
				n_checksum++;
				r.ev = EV_CHECK_ERR;
			end else begin
				r.x = {frame_buf[3], frame_buf[2]};
				r.y = {frame_buf[5], frame_buf[4]};
				r.z = {frame_buf[7], frame_buf[6]};
				if (frame_buf[1] == TYPE_ACCEL) begin
					r.ev = EV_ACCEL;
					r.temp = {frame_buf[9], frame_buf[8]};
					seen_mask = seen_mask | SEEN_ACCEL;
				end else if (frame_buf[1] == TYPE_GYRO) begin
					r.ev = EV_GYRO;
					seen_mask = seen_mask | SEEN_GYRO;
				end else begin
					r.ev = EV_ANGLE;
					seen_mask = seen_mask | SEEN_ANGLE;
				end
				if (seen_mask == SEEN_ALL) begin
					seen_mask = 3'd0;
					n_complete++;
					r.done = 1'b1;
					r.stamp = now;
				end
			end
		end
		if (emit) begin
			r.n_fmt = n_format;
			r.n_sum = n_checksum;
			r.n_cpl = n_complete;
			expected_results.push_back(r);
		end
	endtask

	function automatic logic [31:0] pick_time();
		case ($urandom_range(19))
			0:       return 32'h0000_0000;
			1:       return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [7:0] pick_data();
		case ($urandom_range(9))
			0:       return 8'h00;
			1:       return 8'hFF;
			2:       return 8'h80;
			3:       return 8'h7F;
			default: return 8'($urandom);
		endcase
	endfunction

	function automatic logic [7:0] pick_kind();
		case ($urandom_range(2))
			0:       return TYPE_ACCEL;
			1:       return TYPE_GYRO;
			default: return TYPE_ANGLE;
		endcase
	endfunction

	function automatic logic [7:0] pick_bad_type();
		logic [7:0] b;
		case ($urandom_range(4))
			0: b = TYPE_ACCEL - 8'd1;
			1: b = TYPE_ANGLE + 8'd1;
			2: b = HEADER_BYTE;
			3: b = 8'h00;
			default: begin
				do b = 8'($urandom);
				while (b >= TYPE_ACCEL && b <= TYPE_ANGLE);
			end
		endcase
		return b;
	endfunction

	function automatic logic [63:0] random_body();
		logic [63:0] body;
		for (int i = 0; i < 8; i++)
			body[8*i +: 8] = pick_data();
		return body;
	endfunction

	task automatic push_timed(input logic [7:0] b, input logic [31:0] t);
		byte_queue.push_back('{b, t, 1'b0});
		n_items++;
	endtask

	task automatic push_byte(input logic [7:0] b);
		push_timed(b, pick_time());
	endtask

	// sender waits here until every pending result has been taken
	task automatic push_hold();
		byte_queue.push_back('{8'h00, 32'h0, 1'b1});
	endtask

	task automatic push_frame(input logic [7:0] kind, input logic [63:0] body,
			input bit corrupt);
		logic [7:0] sum;
		sum = HEADER_BYTE + kind;
		for (int i = 0; i < 8; i++)
			sum = sum + body[8*i +: 8];
		if (corrupt)
			sum = sum + 8'($urandom_range(1, 255));
		push_byte(HEADER_BYTE);
		push_byte(kind);
		for (int i = 0; i < 8; i++)
			push_byte(body[8*i +: 8]);
		push_byte(sum);
	endtask

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	// sender
	always @(posedge clk) begin : drive
		bit load;
		load = 1'b0;
		if (arst_n && (!in_valid || in_ready)) begin
			if (byte_queue.size() != 0 && byte_queue[0].hold) begin
				if (!in_valid && !awaiting_results)
					void'(byte_queue.pop_front());
			end else if (byte_queue.size() != 0 && (calm || $urandom_range(99) >= 7)) begin
				load = 1'b1;
			end
			if (load) begin
				rx_byte <= byte_queue[0].b;
				time_ms <= byte_queue[0].t;
				void'(byte_queue.pop_front());
			end
			in_valid <= load;
		end
	end

	// receiver stalls
	always @(posedge clk) begin
		if (arst_n)
			out_ready <= calm || $urandom_range(99) >= 7;
	end

	// monitor: check the result taken at this edge, then predict the byte taken
	always @(posedge clk) begin : watch
		imu_result_t want, got;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					report_mismatch("result transfer with nothing expected");
				end else begin
					want = expected_results.pop_front();
					got.ev    = event_res;
					got.x     = axis_x;
					got.y     = axis_y;
					got.z     = axis_z;
					got.temp  = temp_raw;
					got.done  = sample_complete;
					got.stamp = stamp_ms;
					got.n_fmt = format_errors;
					got.n_sum = checksum_errors;
					got.n_cpl = complete_count;
					check_field("event_res", got.ev, want.ev);
					check_field("axis_x", got.x, want.x);
					check_field("axis_y", got.y, want.y);
					check_field("axis_z", got.z, want.z);
					check_field("temp_raw", got.temp, want.temp);
					check_field("sample_complete", got.done, want.done);
					check_field("stamp_ms", got.stamp, want.stamp);
					check_field("format_errors", got.n_fmt, want.n_fmt);
					check_field("checksum_errors", got.n_sum, want.n_sum);
					check_field("complete_count", got.n_cpl, want.n_cpl);
				end
			end
			if (in_valid && in_ready)
				track_byte(rx_byte, time_ms);
			awaiting_results <= expected_results.size() != 0;
		end
	end

	initial begin : stimulus
		int  pick;
		bit  held;
		held = 1'b0;

		// noise while hunting, at both time extremes
		push_timed(8'h00, 32'h0000_0000);
		push_timed(8'hFF, 32'hFFFF_FFFF);
		// type bytes just outside the valid range
		push_byte(HEADER_BYTE);
		push_byte(TYPE_ACCEL - 8'd1);
		push_byte(HEADER_BYTE);
		push_byte(TYPE_ANGLE + 8'd1);
		// header in the type slot resyncs, then an accel frame with extreme axes
		push_byte(HEADER_BYTE);
		push_frame(TYPE_ACCEL, 64'h0000_FFFF_7FFF_8000, 1'b0);
		push_frame(TYPE_GYRO, random_body(), 1'b1);
		push_hold();

		while (n_items < ITEM_TARGET) begin
			if (!held && n_items >= ITEM_TARGET / 2) begin
				push_hold();
				held = 1'b1;
			end
			pick = $urandom_range(99);
			if (pick < 70) begin
				push_frame(pick_kind(), random_body(), 1'b0);
			end else if (pick < 78) begin
				push_frame(pick_kind(), random_body(), 1'b1);
			end else if (pick < 85) begin
				repeat ($urandom_range(1, 4)) push_byte(8'($urandom));
			end else if (pick < 92) begin
				push_byte(HEADER_BYTE);
				push_byte(pick_bad_type());
			end else begin
				// cut-off frame, the stream has to find its way back
				push_byte(HEADER_BYTE);
				push_byte(pick_kind());
				repeat ($urandom_range(0, 7)) push_byte(pick_data());
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		do @(negedge clk);
		while (byte_queue.size() != 0 || in_valid || awaiting_results);
		repeat (20) @(posedge clk);
		if (expected_results.size() != 0)
			report_mismatch("expected results never arrived");
		if (n_errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	initial begin : watchdog
		#400000;
		$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire
